### hw/rtl/pzma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pzma_pkg
// Shared types, widths and codes of the pressure zero and averaging block.
// ----------------------------------------------------------------------------
package pzma_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int HEAD_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);

  localparam int KIND_W     = 2;
  localparam int SAMPLE_W   = 24;
  localparam int PRESS_W    = 23;
  localparam int ZCNT_W     = 16;
  localparam int LEN_W      = 6;
  localparam int ZSUM_W     = 40;
  localparam int WSUM_W     = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // Shared radix-2 divider.
  localparam int DIV_W      = 40;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int OFS_N      = DIV_W;
  localparam int MOD_N      = FILL_W;
  localparam int AVG_N      = PRESS_W + FILL_W;

  localparam logic [PRESS_W-1:0] PMAX = '1;

  localparam logic [KIND_W-1:0] KIND_CAL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MEAS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_TOL    = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] pressure_sample;
    logic                       sample_valid;
    logic                       cal_permit;
  } item_t;

  typedef struct packed {
    logic               zero_ready;
    logic               pressure_valid;
    logic               below_tolerance;
    logic [PRESS_W-1:0] average_pressure;
  } result_t;

  typedef enum logic [1:0] {
    DIV_OFS = 2'd0,
    DIV_MOD = 2'd1,
    DIV_AVG = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     latch_item;
    logic     cal_acc;
    logic     clear_all;
    logic     set_below;
    logic     meas_rd;
    logic     meas_upd;
    logic     div_go;
    div_sel_t div_sel;
    logic     ofs_write;
    logic     mod_write;
    logic     avg_write;
    logic     avg_sat;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              cal_take;
    logic              cal_done;
    logic              meas_take;
    logic              below;
    logic              div_busy;
    logic              avg_sat;
    logic              out_free;
  } status_t;

endpackage
`default_nettype wire

### hw/rtl/pzma_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pzma_ram
// Single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module pzma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### hw/rtl/pzma_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pzma_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle. The
// dividend is left aligned; iters gives the number of bits to consume.
// ----------------------------------------------------------------------------
module pzma_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [pzma_pkg::DIV_W-1:0]     dividend,
  input  wire logic [pzma_pkg::DIVISOR_W-1:0] divisor,
  input  wire logic [pzma_pkg::DIV_CNT_W-1:0] iters,
  output logic                                busy,
  output logic      [pzma_pkg::DIV_W-1:0]     quotient,
  output logic      [pzma_pkg::DIVISOR_W-1:0] remainder
);

  logic [pzma_pkg::DIV_W-1:0]     dvd;
  logic [pzma_pkg::DIVISOR_W-1:0] rem;
  logic [pzma_pkg::DIV_CNT_W-1:0] cnt;
  logic [pzma_pkg::DIVISOR_W:0]   shifted;
  logic [pzma_pkg::DIVISOR_W+1:0] diff;
  logic                           fits;

  always_comb begin
    shifted = {rem, dvd[pzma_pkg::DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    fits    = !diff[pzma_pkg::DIVISOR_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= (iters != '0);
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == pzma_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Quotient bits shift into the low end of the dividend register.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[pzma_pkg::DIV_W-2:0], fits};
      rem <= fits ? diff[pzma_pkg::DIVISOR_W-1:0] : shifted[pzma_pkg::DIVISOR_W-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule
`default_nettype wire

### hw/rtl/pzma_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pzma_datapath
// Configuration registers, zero calibration state, averaging window, shared
// divider and the result register.
// ----------------------------------------------------------------------------
module pzma_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pzma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pzma_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire pzma_pkg::item_t                 item,
  output pzma_pkg::result_t                    result,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  input  wire pzma_pkg::cmd_t                  cmd,
  output pzma_pkg::status_t                    status
);

  // Configuration.
  logic [pzma_pkg::ZCNT_W-1:0]  zero_sample_count;
  logic [pzma_pkg::LEN_W-1:0]   average_length;
  logic [pzma_pkg::PRESS_W-1:0] negative_tolerance;

  // Item and calibration state.
  pzma_pkg::item_t                   itm;
  logic signed [pzma_pkg::ZSUM_W-1:0]   zero_sum;
  logic [pzma_pkg::ZCNT_W-1:0]          zero_count;
  logic signed [pzma_pkg::SAMPLE_W-1:0] zero_offset;
  logic                                 zero_locked;

  // Window state.
  logic [pzma_pkg::MAX_WINDOW-1:0] wvalid;
  logic [pzma_pkg::HEAD_W-1:0]     head;
  logic [pzma_pkg::FILL_W-1:0]     fill;
  logic [pzma_pkg::WSUM_W-1:0]     wsum;
  logic [pzma_pkg::PRESS_W-1:0]    corr_q;

  // Result under construction.
  logic                         res_pvalid;
  logic                         res_below;
  logic [pzma_pkg::PRESS_W-1:0] res_avg;

  // Combinational helpers.
  logic [pzma_pkg::FILL_W-1:0]       len;
  logic signed [pzma_pkg::SAMPLE_W:0]   corr;
  logic signed [pzma_pkg::SAMPLE_W+1:0] tol_chk;
  logic [pzma_pkg::PRESS_W-1:0]      corr_clamp;
  logic [pzma_pkg::PRESS_W-1:0]      ram_rdata;
  logic [pzma_pkg::PRESS_W-1:0]      old_entry;
  logic                              replace;
  logic [pzma_pkg::WSUM_W-1:0]       wsum_next;
  logic                              zsum_neg;
  logic [pzma_pkg::ZSUM_W-1:0]       zsum_mag;
  logic [pzma_pkg::FILL_W-1:0]       head_inc;
  logic [pzma_pkg::SAMPLE_W-1:0]     ofs_q;

  // Divider operands.
  logic [pzma_pkg::DIV_W-1:0]     div_dividend;
  logic [pzma_pkg::DIVISOR_W-1:0] div_divisor;
  logic [pzma_pkg::DIV_CNT_W-1:0] div_iters;
  logic                           div_busy;
  logic [pzma_pkg::DIV_W-1:0]     div_quot;
  logic [pzma_pkg::DIVISOR_W-1:0] div_rem;

  always_comb begin
    if (int'(average_length) > pzma_pkg::MAX_WINDOW) begin
      len = pzma_pkg::FILL_W'(pzma_pkg::MAX_WINDOW);
    end else begin
      len = pzma_pkg::FILL_W'(average_length);
    end

    corr    = {itm.pressure_sample[pzma_pkg::SAMPLE_W-1], itm.pressure_sample}
            - {zero_offset[pzma_pkg::SAMPLE_W-1], zero_offset};
    tol_chk = {corr[pzma_pkg::SAMPLE_W], corr}
            + $signed({{(pzma_pkg::SAMPLE_W + 2 - pzma_pkg::PRESS_W){1'b0}},
                       negative_tolerance});

    if (corr[pzma_pkg::SAMPLE_W]) begin
      corr_clamp = '0;
    end else if (corr[pzma_pkg::SAMPLE_W-1:pzma_pkg::PRESS_W] != '0) begin
      corr_clamp = pzma_pkg::PMAX;
    end else begin
      corr_clamp = corr[pzma_pkg::PRESS_W-1:0];
    end

    // Entries never written since the last clear read as zero.
    old_entry = wvalid[head] ? ram_rdata : '0;
    replace   = (fill >= len);
    wsum_next = wsum - (replace ? pzma_pkg::WSUM_W'(old_entry) : '0)
              + pzma_pkg::WSUM_W'(corr_q);

    zsum_neg = zero_sum[pzma_pkg::ZSUM_W-1];
    zsum_mag = zsum_neg ? pzma_pkg::ZSUM_W'(-zero_sum) : pzma_pkg::ZSUM_W'(zero_sum);
    head_inc = pzma_pkg::FILL_W'(head) + 1'b1;
    ofs_q    = div_quot[pzma_pkg::SAMPLE_W-1:0];

    case (cmd.div_sel)
      pzma_pkg::DIV_OFS: begin
        div_dividend = zsum_mag;
        div_divisor  = zero_count;
        div_iters    = pzma_pkg::DIV_CNT_W'(pzma_pkg::OFS_N);
      end
      pzma_pkg::DIV_MOD: begin
        div_dividend = {head_inc, {(pzma_pkg::DIV_W - pzma_pkg::MOD_N){1'b0}}};
        div_divisor  = pzma_pkg::DIVISOR_W'(len);
        div_iters    = pzma_pkg::DIV_CNT_W'(pzma_pkg::MOD_N);
      end
      pzma_pkg::DIV_AVG: begin
        div_dividend = {wsum[pzma_pkg::AVG_N-1:0],
                        {(pzma_pkg::DIV_W - pzma_pkg::AVG_N){1'b0}}};
        div_divisor  = pzma_pkg::DIVISOR_W'(fill);
        div_iters    = pzma_pkg::DIV_CNT_W'(pzma_pkg::AVG_N);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
        div_iters    = '0;
      end
    endcase
  end

  always_comb begin
    status.kind      = itm.kind;
    status.cal_take  = !zero_locked && itm.cal_permit && itm.sample_valid
                       && (zero_sample_count != '0);
    status.cal_done  = (zero_count >= zero_sample_count);
    status.meas_take = zero_locked && itm.sample_valid && (len != '0);
    status.below     = tol_chk[pzma_pkg::SAMPLE_W+1];
    status.div_busy  = div_busy;
    // The average would not fit in 23 bits when sum >= fill * 2^23.
    status.avg_sat   = (wsum[pzma_pkg::WSUM_W-1:pzma_pkg::PRESS_W]
                        >= (pzma_pkg::WSUM_W - pzma_pkg::PRESS_W)'(fill));
    status.out_free  = !result_valid || result_ready;
  end

  pzma_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .iters     (div_iters),
    .busy      (div_busy),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  pzma_ram #(
    .WIDTH (pzma_pkg::PRESS_W),
    .DEPTH (pzma_pkg::MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (cmd.meas_upd),
    .addr  (head),
    .wdata (corr_q),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_sample_count  <= '0;
      average_length     <= '0;
      negative_tolerance <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pzma_pkg::CFG_ZERO_COUNT: zero_sample_count  <= cfg_data[pzma_pkg::ZCNT_W-1:0];
        pzma_pkg::CFG_AVG_LEN:    average_length     <= cfg_data[pzma_pkg::LEN_W-1:0];
        pzma_pkg::CFG_NEG_TOL:    negative_tolerance <= cfg_data[pzma_pkg::PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      zero_sum    <= '0;
      zero_count  <= '0;
      zero_offset <= '0;
      zero_locked <= 1'b0;
      wvalid      <= '0;
      head        <= '0;
      fill        <= '0;
      wsum        <= '0;
    end else begin
      if (cmd.cal_acc) begin
        zero_sum   <= zero_sum + pzma_pkg::ZSUM_W'(itm.pressure_sample);
        zero_count <= zero_count + 1'b1;
      end
      if (cmd.ofs_write) begin
        zero_offset <= zsum_neg ? -ofs_q : ofs_q;
        zero_locked <= 1'b1;
        wvalid      <= '0;
        head        <= '0;
        fill        <= '0;
        wsum        <= '0;
      end
      if (cmd.meas_upd) begin
        wsum         <= wsum_next;
        wvalid[head] <= 1'b1;
        if (!replace) begin
          fill <= fill + 1'b1;
        end
      end
      if (cmd.mod_write) begin
        head <= div_rem[pzma_pkg::HEAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      itm <= item;
    end
    if (cmd.meas_rd) begin
      corr_q <= corr_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      res_pvalid <= 1'b0;
      res_below  <= 1'b0;
      res_avg    <= '0;
    end else begin
      if (cmd.set_below) begin
        res_below <= 1'b1;
      end
      if (cmd.avg_sat) begin
        res_pvalid <= 1'b1;
        res_avg    <= pzma_pkg::PMAX;
      end
      if (cmd.avg_write) begin
        res_pvalid <= 1'b1;
        res_avg    <= div_quot[pzma_pkg::PRESS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.zero_ready       <= zero_locked;
      result.pressure_valid   <= res_pvalid;
      result.below_tolerance  <= res_below;
      result.average_pressure <= res_avg;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pzma_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pzma_ctrl
// Sequencer: decodes each word and steps the datapath through calibration,
// window update and the divider passes.
// ----------------------------------------------------------------------------
module pzma_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire pzma_pkg::status_t status,
  output pzma_pkg::cmd_t         cmd
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_DECODE   = 14'b00000000000010,
    ST_CAL_ACC  = 14'b00000000000100,
    ST_CAL_CHK  = 14'b00000000001000,
    ST_OFS_GO   = 14'b00000000010000,
    ST_OFS_WAIT = 14'b00000000100000,
    ST_RD       = 14'b00000001000000,
    ST_UPD      = 14'b00000010000000,
    ST_MOD_GO   = 14'b00000100000000,
    ST_MOD_WAIT = 14'b00001000000000,
    ST_AVG_CHK  = 14'b00010000000000,
    ST_AVG_GO   = 14'b00100000000000,
    ST_AVG_WAIT = 14'b01000000000000,
    ST_DONE     = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = pzma_pkg::DIV_OFS;
    item_ready  = 1'b0;

    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.kind)
          pzma_pkg::KIND_CAL: begin
            state_next = status.cal_take ? ST_CAL_ACC : ST_DONE;
          end
          pzma_pkg::KIND_MEAS: begin
            if (!status.meas_take) begin
              state_next = ST_DONE;
            end else if (status.below) begin
              cmd.set_below = 1'b1;
              state_next    = ST_DONE;
            end else begin
              state_next = ST_RD;
            end
          end
          pzma_pkg::KIND_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_next    = ST_DONE;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_CAL_ACC: begin
        cmd.cal_acc = 1'b1;
        state_next  = ST_CAL_CHK;
      end
      ST_CAL_CHK: begin
        state_next = status.cal_done ? ST_OFS_GO : ST_DONE;
      end
      ST_OFS_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = pzma_pkg::DIV_OFS;
        state_next  = ST_OFS_WAIT;
      end
      ST_OFS_WAIT: begin
        cmd.div_sel = pzma_pkg::DIV_OFS;
        if (!status.div_busy) begin
          cmd.ofs_write = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_RD: begin
        // The window RAM is read at the head while the clamped value settles.
        cmd.meas_rd = 1'b1;
        state_next  = ST_UPD;
      end
      ST_UPD: begin
        cmd.meas_upd = 1'b1;
        state_next   = ST_MOD_GO;
      end
      ST_MOD_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = pzma_pkg::DIV_MOD;
        state_next  = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        cmd.div_sel = pzma_pkg::DIV_MOD;
        if (!status.div_busy) begin
          cmd.mod_write = 1'b1;
          state_next    = ST_AVG_CHK;
        end
      end
      ST_AVG_CHK: begin
        if (status.avg_sat) begin
          cmd.avg_sat = 1'b1;
          state_next  = ST_DONE;
        end else begin
          state_next = ST_AVG_GO;
        end
      end
      ST_AVG_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = pzma_pkg::DIV_AVG;
        state_next  = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        cmd.div_sel = pzma_pkg::DIV_AVG;
        if (!status.div_busy) begin
          cmd.avg_write = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/pressure_zero_and_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_zero_and_moving_average
// Differential pressure conditioner: zero offset calibration and a moving
// average over a ring window, one result word per input word.
// ----------------------------------------------------------------------------
//   Channel   Signals                          Direction  Content
//   item      item_valid/item_ready, item      in         pzma_pkg::item_t
//   result    result_valid/result_ready,result out        pzma_pkg::result_t
//   config    cfg_we, cfg_index, cfg_data      in         register writes
//
// One word is in work at a time. A measurement that enters the window runs the shared
// radix-2 divider for the head wrap (6 steps) and, unless the average saturates, for the
// average (29 steps). A calibration word that completes the zero adds the 40-step offset
// division. A new word is accepted while the previous result waits; its own result then
// holds until that one leaves.
// After reset the window is empty at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module pressure_zero_and_moving_average (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire pzma_pkg::item_t                 item,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output pzma_pkg::result_t                    result,
  input  wire logic                            cfg_we,
  input  wire logic [pzma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pzma_pkg::CFG_DATA_W-1:0] cfg_data
);

  pzma_pkg::cmd_t    cmd;
  pzma_pkg::status_t status;

  pzma_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pzma_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
`default_nettype wire

### tb/pzma_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pzma_result_checker
// Watches the item, result and register ports of the pressure conditioner,
// keeps its own copy of the calibration and window state, works out the
// result word of every accepted item word and compares it field by field with
// the words that the block returns.
// ----------------------------------------------------------------------------
module pzma_result_checker
  import pzma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    words_checked,
  output int                    averages_seen,
  output int                    saturated_seen,
  output int                    below_seen,
  output int                    zeros_set
);

  // Register copies.
  logic [ZCNT_W-1:0]  zero_count_cfg = '0;
  logic [LEN_W-1:0]   avg_len_cfg    = '0;
  logic [PRESS_W-1:0] neg_tol_cfg    = '0;

  // Calibration and window state.
  longint             zero_sum    = 0;
  logic [ZCNT_W-1:0]  zero_count  = '0;
  longint             zero_offset = 0;
  logic               zero_locked = 1'b0;
  logic [PRESS_W-1:0] window [MAX_WINDOW];
  int                 head = 0;
  int                 fill = 0;
  longint unsigned    window_sum = 0;

  result_t awaited_results[$];
  int      errors = 0;
  int      checked = 0;
  int      n_avg = 0;
  int      n_sat = 0;
  int      n_below = 0;
  int      n_zero = 0;

  task automatic clear_window();
    for (int i = 0; i < MAX_WINDOW; i++) window[i] = '0;
    head = 0;
    fill = 0;
    window_sum = 0;
  endtask

  task automatic clear_conditioning();
    zero_sum = 0;
    zero_count = '0;
    zero_offset = 0;
    zero_locked = 1'b0;
    clear_window();
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] result word %0d: %s is %0h, expected %0h", $time, checked, what, got,
             want);
    errors++;
  endtask

  // Applies one item word to the state copy and returns the result word it causes.
  task automatic condition_word(input item_t w, output result_t r);
    longint          p;
    longint          corr;
    int              len;
    longint unsigned quo;
    r = '0;
    p = longint'($signed(w.pressure_sample));
    case (w.kind)
      KIND_CAL: begin
        if (!zero_locked && w.cal_permit && w.sample_valid && zero_count_cfg != 0) begin
          zero_sum += p;
          zero_count = zero_count + 1'b1;
          // A count lowered below the progress made completes on this sample.
          if (zero_count >= zero_count_cfg) begin
            zero_offset = (zero_count == 0) ? 0 : zero_sum / longint'(zero_count);
            zero_locked = 1'b1;
            n_zero++;
            clear_window();
          end
        end
      end
      KIND_MEAS: begin
        len = (avg_len_cfg > MAX_WINDOW) ? MAX_WINDOW : int'(avg_len_cfg);
        if (zero_locked && w.sample_valid && len != 0) begin
          corr = p - zero_offset;
          if (corr < -longint'(neg_tol_cfg)) begin
            r.below_tolerance = 1'b1;
            n_below++;
          end else begin
            if (corr < 0) corr = 0;
            if (corr > longint'(PMAX)) corr = longint'(PMAX);
            if (head >= MAX_WINDOW) head = 0;
            // With the length lowered under the fill, the window counts as full.
            if (fill >= len) window_sum -= window[head];
            else fill++;
            window[head] = corr[PRESS_W-1:0];
            window_sum += longint'(corr);
            head = (head + 1) % len;
            quo = window_sum / longint'(fill);
            if (quo > longint'(PMAX)) begin
              quo = longint'(PMAX);
              n_sat++;
            end
            r.pressure_valid = 1'b1;
            r.average_pressure = quo[PRESS_W-1:0];
            n_avg++;
          end
        end
      end
      KIND_CLEAR: clear_conditioning();
      default: ;
    endcase
    r.zero_ready = zero_locked;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t next_word;
    if (rst) begin
      zero_count_cfg = '0;
      avg_len_cfg = '0;
      neg_tol_cfg = '0;
      clear_conditioning();
      awaited_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          report("word with nothing awaited", result, 0);
        end else begin
          want = awaited_results.pop_front();
          if (result.zero_ready !== want.zero_ready)
            report("zero_ready", result.zero_ready, want.zero_ready);
          if (result.pressure_valid !== want.pressure_valid)
            report("pressure_valid", result.pressure_valid, want.pressure_valid);
          if (result.below_tolerance !== want.below_tolerance)
            report("below_tolerance", result.below_tolerance, want.below_tolerance);
          if (result.average_pressure !== want.average_pressure)
            report("average_pressure", result.average_pressure, want.average_pressure);
        end
        checked++;
      end
      if (item_valid && item_ready) begin
        condition_word(item, next_word);
        awaited_results.push_back(next_word);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ZERO_COUNT: zero_count_cfg = cfg_data[ZCNT_W-1:0];
          CFG_AVG_LEN:    avg_len_cfg = cfg_data[LEN_W-1:0];
          CFG_NEG_TOL:    neg_tol_cfg = cfg_data[PRESS_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches     <= errors;
    pending        <= awaited_results.size();
    words_checked  <= checked;
    averages_seen  <= n_avg;
    saturated_seen <= n_sat;
    below_seen     <= n_below;
    zeros_set      <= n_zero;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the pressure conditioner: a directed run through zero
// calibration, tolerance and window corner cases, then phases of random
// calibration and measurement traffic under changing register settings, with
// bursty input and a stalling result receiver. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import pzma_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam longint SAMPLE_MAX = 8388607;
  localparam longint SAMPLE_MIN = -8388608;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ZERO_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int words_checked;
  int averages_seen;
  int saturated_seen;
  int below_seen;
  int zeros_set;

  int          burst_left = 8;
  int          sent_kind [4] = '{0, 0, 0, 0};
  int          idle_cycles = 0;
  logic [15:0] rx_cycle = '0;
  int          stall_left = 0;

  pressure_zero_and_moving_average dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pzma_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .words_checked  (words_checked),
    .averages_seen  (averages_seen),
    .saturated_seen (saturated_seen),
    .below_seen     (below_seen),
    .zeros_set      (zeros_set)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver cycles through always ready, sparse stalls, a fixed one in
  // eight pattern and long random stalls.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[10:9])
      2'd0: result_ready <= 1'b1;
      2'd1: result_ready <= ($urandom_range(0, 3) != 0);
      2'd2: result_ready <= (rx_cycle[2:0] == 3'd0);
      default: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
          result_ready <= 1'b0;
        end else begin
          result_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 40);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no handshake for %0d cycles, %0d words outstanding", IDLE_LIMIT, pending);
        $display("pressure_zero_and_moving_average regression: fail");
        $finish;
      end
    end
  end

  function automatic item_t mk(logic [KIND_W-1:0] k, longint p, bit v, bit a);
    item_t w;
    if (p > SAMPLE_MAX) p = SAMPLE_MAX;
    if (p < SAMPLE_MIN) p = SAMPLE_MIN;
    w.kind = k;
    w.pressure_sample = p[SAMPLE_W-1:0];
    w.sample_valid = v;
    w.cal_permit = a;
    return w;
  endfunction

  // Mostly calibration samples and readings near the phase's zero level, with
  // some full-range and extreme samples, clears and unused kinds.
  function automatic item_t random_word(longint base);
    int                pick;
    logic [KIND_W-1:0] k;
    logic [31:0]       raw;
    longint            p;
    pick = $urandom_range(0, 99);
    if (pick < 18) k = KIND_CAL;
    else if (pick < 90) k = KIND_MEAS;
    else if (pick < 95) k = KIND_CLEAR;
    else k = KIND_UNUSED;
    raw = $urandom();
    case ($urandom_range(0, 9))
      0: p = longint'($signed(raw[SAMPLE_W-1:0]));
      1: p = raw[31] ? SAMPLE_MAX : SAMPLE_MIN;
      default: begin
        if (k == KIND_CAL) p = base + longint'($urandom_range(0, 1000)) - 500;
        else p = base + longint'($urandom_range(0, 40000)) - 4000;
      end
    endcase
    return mk(k, p, $urandom_range(0, 15) != 0, $urandom_range(0, 7) != 0);
  endfunction

  // Valid stays high across back-to-back words of a burst.
  task automatic send(input item_t w);
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent_kind[w.kind]++;
    burst_left--;
    if (burst_left <= 0) begin
      item_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  // Drops valid and holds off until every awaited result word has come back.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int zero_n, input int len, input int tol);
    drain();
    write_reg(CFG_ZERO_COUNT, CFG_DATA_W'(zero_n));
    write_reg(CFG_AVG_LEN, CFG_DATA_W'(len));
    write_reg(CFG_NEG_TOL, CFG_DATA_W'(tol));
  endtask

  initial begin : stimulus
    longint base;
    int     n_items;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still at reset: calibration is off and no zero exists.
    send(mk(KIND_CAL, 500, 1, 1));
    send(mk(KIND_MEAS, 500, 1, 1));
    set_regs(4, 4, 100);
    send(mk(KIND_UNUSED, -1, 1, 1));
    send(mk(KIND_CAL, 700, 1, 0));
    send(mk(KIND_CAL, 700, 0, 1));
    // Zero from the sample extremes: (-1 + 1000 - 3) / 4 truncates to 249.
    send(mk(KIND_CAL, SAMPLE_MAX, 1, 1));
    send(mk(KIND_CAL, SAMPLE_MIN, 1, 1));
    send(mk(KIND_CAL, 1000, 1, 1));
    send(mk(KIND_CAL, -3, 1, 1));
    send(mk(KIND_CAL, 5000, 1, 1));
    send(mk(KIND_MEAS, 300, 0, 1));
    send(mk(KIND_MEAS, 249, 1, 0));
    send(mk(KIND_MEAS, SAMPLE_MAX, 1, 1));
    send(mk(KIND_MEAS, 149, 1, 1));
    send(mk(KIND_MEAS, 148, 1, 1));
    send(mk(KIND_MEAS, SAMPLE_MIN, 1, 1));
    send(mk(KIND_MEAS, 2249, 1, 1));
    send(mk(KIND_CLEAR, 0, 0, 0));

    // Count lowered below the progress made: the next sample completes it.
    set_regs(5, 32, 0);
    send(mk(KIND_CAL, 0, 1, 1));
    send(mk(KIND_CAL, 10, 1, 1));
    drain();
    write_reg(CFG_ZERO_COUNT, 1);
    send(mk(KIND_CAL, 20, 1, 1));

    // Two full-scale entries, then the length cut to two, equal to the fill, with the head
    // past it: the sum keeps a stale entry and the average saturates.
    send(mk(KIND_MEAS, SAMPLE_MAX, 1, 1));
    send(mk(KIND_MEAS, SAMPLE_MAX, 1, 1));
    drain();
    write_reg(CFG_AVG_LEN, 2);
    write_reg(CFG_NEG_TOL, PMAX);
    send(mk(KIND_MEAS, SAMPLE_MAX, 1, 1));
    send(mk(KIND_MEAS, SAMPLE_MIN, 1, 1));

    for (int ph = 0; ph < 7; ph++) begin
      n_items = 118;
      case (ph)
        0: set_regs(1, 1, 0);
        1: set_regs(3, 32, $urandom_range(0, 3000));
        2: set_regs(8, 63, int'(PMAX));
        3: begin
          set_regs(16'hFFFF, $urandom_range(2, 31), $urandom_range(0, 3000));
          n_items = 30;
        end
        4: begin
          set_regs($urandom_range(1, 6), 0, $urandom_range(0, 3000));
          n_items = 30;
        end
        5: set_regs($urandom_range(1, 6), $urandom_range(1, 63), $urandom_range(0, 3000));
        default: set_regs(2, $urandom_range(0, 63), $urandom_range(0, PMAX));
      endcase
      base = longint'($urandom_range(0, 400000)) - 200000;
      if ($urandom_range(0, 1) != 0) send(mk(KIND_CLEAR, 0, 0, 0));
      for (int i = 0; i < n_items; i++) begin
        if (ph == 5 && i == n_items / 2) drain();
        send(random_word(base));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d calibration, %0d measurement, %0d clear and %0d unused words",
             sent_kind[KIND_CAL], sent_kind[KIND_MEAS], sent_kind[KIND_CLEAR],
             sent_kind[KIND_UNUSED]);
    $display("checked %0d results: %0d zeros set, %0d averages (%0d saturated), %0d below",
             words_checked, zeros_set, averages_seen, saturated_seen, below_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("pressure_zero_and_moving_average regression: pass");
    end else begin
      $display("pressure_zero_and_moving_average regression: fail");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/pzma_pkg.sv
hw/rtl/pzma_ram.sv
hw/rtl/pzma_div.sv
hw/rtl/pzma_datapath.sv
hw/rtl/pzma_ctrl.sv
hw/rtl/pressure_zero_and_moving_average.sv
tb/pzma_result_checker.sv
tb/tb_top.sv
